@@ hdl/sgfr_pkg.sv @@
// Shared types and constants of the group size filter and relabel block.
package sgfr_pkg;

   localparam int LABEL_W = 10;
   localparam int FUNC_W = 2;
   localparam int MIN_W = 16;
   localparam int MAX_GROUPS_DEF = 1024;
   localparam int COUNT_BITS_DEF = 16;
   localparam int Q_DEPTH = 2;
   localparam logic [MIN_W-1:0] MIN_MEMBERS_RESET = 16'd8;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELABEL = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [LABEL_W-1:0] group_label;
   } req_item_type;

   typedef struct packed {
      logic [LABEL_W-1:0] new_label;
      logic [LABEL_W-1:0] surviving_groups;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_COUNT,
      OP_RELABEL
   } op_type;

   typedef struct packed {
      op_type op;
      logic [LABEL_W-1:0] group_label;
      logic in_range;
   } q_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_CNT_WR,
      ST_BUILD,
      ST_RL_RD,
      ST_RL_OUT
   } state_type;

endpackage

@@ hdl/sgfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sgfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sgfr_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
module sgfr_front #(
   parameter int MAX_GROUPS = sgfr_pkg::MAX_GROUPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sgfr_pkg::req_item_type req_item,
   input  logic                  init_busy,
   output logic                  q_valid,
   output sgfr_pkg::q_item_type  q_item,
   input  logic                  q_pop
);

   localparam int PW = (sgfr_pkg::Q_DEPTH > 1) ? $clog2(sgfr_pkg::Q_DEPTH) : 1;
   localparam int CW = $clog2(sgfr_pkg::Q_DEPTH + 1);

   sgfr_pkg::q_item_type q_mem_ff [sgfr_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] q_cnt_ff, q_cnt_in;
   logic accept;
   logic push;
   logic full;
   sgfr_pkg::q_item_type new_item;

   assign full = (q_cnt_ff == CW'(sgfr_pkg::Q_DEPTH));
   assign busy = reset | init_busy | full;
   assign accept = start & ~busy;

   // classify: drop unused codes, flag out-of-range labels
   always_comb begin
      new_item.group_label = req_item.group_label;
      new_item.in_range = (32'(req_item.group_label) < 32'(MAX_GROUPS));
      new_item.op = sgfr_pkg::OP_CLEAR;
      push = 1'b0;
      case (req_item.func)
         sgfr_pkg::FUNC_CLEAR: begin
            new_item.op = sgfr_pkg::OP_CLEAR;
            push = accept;
         end
         sgfr_pkg::FUNC_COUNT: begin
            new_item.op = sgfr_pkg::OP_COUNT;
            push = accept;
         end
         sgfr_pkg::FUNC_RELABEL: begin
            new_item.op = sgfr_pkg::OP_RELABEL;
            push = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      q_cnt_in = q_cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(sgfr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(sgfr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !q_pop) begin
         q_cnt_in = q_cnt_ff + CW'(1);
      end else if (!push && q_pop) begin
         q_cnt_in = q_cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_valid = (q_cnt_ff != '0);
   assign q_item = q_mem_ff[rd_ptr_ff];

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

@@ hdl/sgfr_back.sv @@
// Back end: count store, map build sweep, relabel lookup and result register.
module sgfr_back #(
   parameter int MAX_GROUPS = sgfr_pkg::MAX_GROUPS_DEF,
   parameter int COUNT_BITS = sgfr_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [sgfr_pkg::MIN_W-1:0]  csr_wr_data,
   input  logic                        q_valid,
   input  sgfr_pkg::q_item_type        q_item,
   output logic                        q_pop,
   output logic                        init_busy,
   output logic                        rsp_strobe,
   output sgfr_pkg::rsp_item_type      rsp_item
);

   localparam int AW = $clog2(MAX_GROUPS);
   localparam int LX = (AW > sgfr_pkg::LABEL_W) ? AW : sgfr_pkg::LABEL_W;
   localparam int MW = (COUNT_BITS > sgfr_pkg::MIN_W) ? COUNT_BITS : sgfr_pkg::MIN_W;
   localparam logic [AW-1:0] LAST = AW'(MAX_GROUPS - 1);

   sgfr_pkg::state_type state_ff, state_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic [AW-1:0] next_ff, next_in;
   logic [AW-1:0] kept_ff, kept_in;
   logic map_ready_ff, map_ready_in;
   logic [sgfr_pkg::MIN_W-1:0] min_ff;
   sgfr_pkg::q_item_type cur_ff, cur_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   sgfr_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic cnt_we;
   logic [AW-1:0] cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
   logic map_we;
   logic [AW-1:0] map_waddr, map_raddr;
   logic [sgfr_pkg::LABEL_W-1:0] map_wdata, map_rdata;

   logic [AW-1:0] head_addr, cur_addr, next_plus;
   logic keep;

   assign head_addr = AW'(LX'(q_item.group_label));
   assign cur_addr = AW'(LX'(cur_ff.group_label));
   assign next_plus = next_ff + AW'(1);
   assign keep = (walk_ff != '0) && (cnt_rdata != '0) && (MW'(cnt_rdata) >= MW'(min_ff));

   sgfr_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_GROUPS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   sgfr_ram #(.WIDTH(sgfr_pkg::LABEL_W), .DEPTH(MAX_GROUPS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   always_comb begin
      state_in = state_ff;
      walk_in = walk_ff;
      next_in = next_ff;
      kept_in = kept_ff;
      map_ready_in = map_ready_ff;
      cur_in = cur_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in = rsp_item_ff;
      q_pop = 1'b0;
      cnt_we = 1'b0;
      cnt_waddr = walk_ff;
      cnt_wdata = '0;
      cnt_raddr = '0;
      map_we = 1'b0;
      map_waddr = walk_ff;
      map_wdata = '0;
      map_raddr = cur_addr;
      case (state_ff)
         sgfr_pkg::ST_INIT, sgfr_pkg::ST_CLEAR: begin
            // zero one count per cycle
            cnt_we = 1'b1;
            map_ready_in = 1'b0;
            kept_in = '0;
            walk_in = walk_ff + AW'(1);
            if (walk_ff == LAST) begin
               walk_in = '0;
               state_in = sgfr_pkg::ST_IDLE;
            end
         end
         sgfr_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_item;
               case (q_item.op)
                  sgfr_pkg::OP_CLEAR: begin
                     walk_in = '0;
                     map_ready_in = 1'b0;
                     kept_in = '0;
                     state_in = sgfr_pkg::ST_CLEAR;
                  end
                  sgfr_pkg::OP_COUNT: begin
                     map_ready_in = 1'b0;
                     cnt_raddr = head_addr;
                     if (q_item.in_range) begin
                        state_in = sgfr_pkg::ST_CNT_WR;
                     end
                  end
                  sgfr_pkg::OP_RELABEL: begin
                     if (map_ready_ff) begin
                        map_raddr = head_addr;
                        state_in = sgfr_pkg::ST_RL_OUT;
                     end else begin
                        cnt_raddr = '0;
                        walk_in = '0;
                        next_in = '0;
                        state_in = sgfr_pkg::ST_BUILD;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         sgfr_pkg::ST_CNT_WR: begin
            // saturating increment
            cnt_we = 1'b1;
            cnt_waddr = cur_addr;
            cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
            state_in = sgfr_pkg::ST_IDLE;
         end
         sgfr_pkg::ST_BUILD: begin
            map_we = 1'b1;
            map_wdata = keep ? sgfr_pkg::LABEL_W'(LX'(next_plus)) : '0;
            if (keep) begin
               next_in = next_plus;
            end
            cnt_raddr = walk_ff + AW'(1);
            if (walk_ff == LAST) begin
               kept_in = keep ? next_plus : next_ff;
               map_ready_in = 1'b1;
               walk_in = '0;
               state_in = sgfr_pkg::ST_RL_RD;
            end else begin
               walk_in = walk_ff + AW'(1);
            end
         end
         sgfr_pkg::ST_RL_RD: begin
            map_raddr = cur_addr;
            state_in = sgfr_pkg::ST_RL_OUT;
         end
         sgfr_pkg::ST_RL_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in.new_label = cur_ff.in_range ? map_rdata : '0;
            rsp_item_in.surviving_groups = sgfr_pkg::LABEL_W'(LX'(kept_ff));
            state_in = sgfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = sgfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgfr_pkg::ST_INIT;
         walk_ff <= '0;
         next_ff <= '0;
         kept_ff <= '0;
         map_ready_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         min_ff <= sgfr_pkg::MIN_MEMBERS_RESET;
      end else begin
         state_ff <= state_in;
         walk_ff <= walk_in;
         next_ff <= next_in;
         kept_ff <= kept_in;
         map_ready_ff <= map_ready_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            min_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign init_busy = (state_ff == sgfr_pkg::ST_INIT);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff) else $error("result strobe held two cycles");

   a_build_ends_in_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgfr_pkg::ST_BUILD && walk_ff == LAST) |=>
      (state_ff == sgfr_pkg::ST_RL_RD && map_ready_ff)) else $error("map build did not finish");

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgfr_pkg::ST_BUILD) |-> (next_ff <= walk_ff))
      else $error("kept count ran ahead of walk");

   a_no_pop_outside_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == sgfr_pkg::ST_IDLE)) else $error("pop while back end busy");

endmodule

@@ hdl/small_group_filter_relabel.sv @@
// Top level of the group size filter and compact relabel block.
//
//   channel  ports                         handshake
//   request  start, busy, req_item         taken when start high and busy low
//   result   rsp_strobe, rsp_item          one cycle per result, no back-pressure
//   csr      csr_wr_en, csr_wr_data        min_members, written when csr_wr_en high
//
// Count item in the back end: a count RAM read, then a write (no write for an out-of-range label).
// Relabel item with a built map: map RAM read from idle, then ST_RL_OUT, then the result register.
// First relabel after reset, clear or count: a map build sweep, one count RAM read a label, then the lookup.
// Clear item and reset both sweep the count RAM to zero; busy stays high through the reset sweep,
// not through a clear sweep.
// A two-entry queue keeps taking items while the back end works; busy rises when it is full.
module small_group_filter_relabel #(
   parameter int MAX_GROUPS = sgfr_pkg::MAX_GROUPS_DEF,
   parameter int COUNT_BITS = sgfr_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  sgfr_pkg::req_item_type     req_item,
   output logic                       rsp_strobe,
   output sgfr_pkg::rsp_item_type     rsp_item,
   input  logic                       csr_wr_en,
   input  logic [sgfr_pkg::MIN_W-1:0] csr_wr_data
);

   logic q_valid;
   logic q_pop;
   logic init_busy;
   sgfr_pkg::q_item_type q_item;

   sgfr_front #(.MAX_GROUPS(MAX_GROUPS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .init_busy (init_busy),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   sgfr_back #(.MAX_GROUPS(MAX_GROUPS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .init_busy   (init_busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule

@@ dv/tb_small_group_filter_relabel.sv @@
// Self-checking testbench for the group size filter and compact relabel block.
`timescale 1ns / 100ps

module tb_small_group_filter_relabel;
   import sgfr_pkg::*;

   localparam int PERIOD = 12;
   localparam int MAX_G = MAX_GROUPS_DEF;
   localparam int COUNT_W = COUNT_BITS_DEF;
   localparam int DRAIN_CYCLES = 3 * (MAX_G + 8);
   localparam int TIMEOUT_CYCLES = 3_000_000;
   localparam int RANDOM_ITEMS = 1000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [LABEL_W-1:0] TOP_LABEL = LABEL_W'(MAX_G - 1);

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CHECK,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      req_item_type item;
      logic [MIN_W-1:0] csr_val;
      rsp_item_type rsp;
   } dir_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_item_type req_item;
   logic rsp_strobe;
   rsp_item_type rsp_item;
   logic csr_wr_en;
   logic [MIN_W-1:0] csr_wr_data;

   logic [COUNT_W-1:0] member_tally [MAX_G];
   logic [LABEL_W-1:0] dense_map [MAX_G];
   bit map_built;
   logic [LABEL_W-1:0] kept_groups;
   logic [MIN_W-1:0] min_size;

   rsp_item_type relabel_q [$];
   rsp_item_type head_rsp;
   dir_row_type dir_tab [$];
   int errors;
   int items_sent;
   bit idle_on;
   int unsigned pool [12];
   int n_pool;
   int n_count;
   int n_relabel;
   bit recounted;

   small_group_filter_relabel dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always #(PERIOD / 2) clock = ~clock;

   function automatic bit predict_relabel(input req_item_type it, output rsp_item_type r);
      int unsigned next;
      r = '0;
      case (it.func)
         FUNC_CLEAR: begin
            foreach (member_tally[g]) member_tally[g] = '0;
            map_built = 1'b0;
            kept_groups = '0;
            return 1'b0;
         end
         FUNC_COUNT: begin
            if (member_tally[it.group_label] != '1)
               member_tally[it.group_label] = member_tally[it.group_label] + 1'b1;
            map_built = 1'b0;
            return 1'b0;
         end
         FUNC_RELABEL: begin
            if (!map_built) begin
               next = 0;
               dense_map[0] = '0;
               for (int g = 1; g < MAX_G; g++) begin
                  if (member_tally[g] == '0 || member_tally[g] < min_size) begin
                     dense_map[g] = '0;
                  end else begin
                     next++;
                     dense_map[g] = LABEL_W'(next);
                  end
               end
               kept_groups = LABEL_W'(next);
               map_built = 1'b1;
            end
            r.new_label = dense_map[it.group_label];
            r.surviving_groups = kept_groups;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic dir_row_type make_row(input row_kind_type k, input logic [FUNC_W-1:0] f,
                                            input logic [MIN_W-1:0] v,
                                            input logic [LABEL_W-1:0] nl,
                                            input logic [LABEL_W-1:0] sg);
      dir_row_type row;
      row.kind = k;
      row.item.func = f;
      row.item.group_label = v[LABEL_W-1:0];
      row.csr_val = v;
      row.rsp.new_label = nl;
      row.rsp.surviving_groups = sg;
      return row;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic send_item(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type pred;
      bit has_rsp;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      has_rsp = predict_relabel(it, pred);
      if (has_rsp) relabel_q.push_back(typed ? want : pred);
      if (it.func != FUNC_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_op(input logic [FUNC_W-1:0] f, input logic [LABEL_W-1:0] l);
      req_item_type it;
      it.func = f;
      it.group_label = l;
      send_item(it, 1'b0, '0);
   endtask

   task automatic drain_and_wait();
      start <= 1'b0;
      while (relabel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_min(input logic [MIN_W-1:0] v);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      min_size = v;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (relabel_q.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            head_rsp = relabel_q.pop_front();
            if (rsp_item.new_label !== head_rsp.new_label)
               report_mismatch($sformatf("new_label %0d, expected %0d",
                                         rsp_item.new_label, head_rsp.new_label));
            if (rsp_item.surviving_groups !== head_rsp.surviving_groups)
               report_mismatch($sformatf("surviving_groups %0d, expected %0d",
                                         rsp_item.surviving_groups, head_rsp.surviving_groups));
         end
      end
   end

   initial begin
      #(longint'(TIMEOUT_CYCLES) * PERIOD);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      errors = 0;
      items_sent = 0;
      idle_on = 1'b1;
      foreach (member_tally[g]) member_tally[g] = '0;
      foreach (dense_map[g]) dense_map[g] = '0;
      map_built = 1'b0;
      kept_groups = '0;
      min_size = MIN_MEMBERS_RESET;

      dir_tab.push_back(make_row(ROW_CHECK, FUNC_RELABEL, 0, 0, 0));
      dir_tab.push_back(make_row(ROW_CHECK, FUNC_RELABEL, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_UNUSED, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_CSR, FUNC_CLEAR, 2, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, 3, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, 0, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, 0, 0, 0));
      dir_tab.push_back(make_row(ROW_CHECK, FUNC_RELABEL, MIN_W'(TOP_LABEL), 1, 1));
      dir_tab.push_back(make_row(ROW_CHECK, FUNC_RELABEL, 3, 0, 1));
      dir_tab.push_back(make_row(ROW_CHECK, FUNC_RELABEL, 0, 0, 1));
      dir_tab.push_back(make_row(ROW_CSR, FUNC_CLEAR, 0, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_RELABEL, 3, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, 3, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_RELABEL, 3, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_RELABEL, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_RELABEL, 682, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_COUNT, 341, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_UNUSED, 341, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_RELABEL, 341, 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_CLEAR, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_CHECK, FUNC_RELABEL, MIN_W'(TOP_LABEL), 0, 0));
      dir_tab.push_back(make_row(ROW_ITEM, FUNC_UNUSED, 0, 0, 0));

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            drain_and_wait();
            write_min(dir_tab[i].csr_val);
         end else begin
            send_item(dir_tab[i].item, dir_tab[i].kind == ROW_CHECK, dir_tab[i].rsp);
         end
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 2) == 0) begin
            drain_and_wait();
            case ($urandom_range(0, 7))
               0: write_min('0);
               1: write_min(16'd1);
               6: write_min('1);
               7: write_min(MIN_W'($urandom));
               default: write_min(MIN_W'($urandom_range(2, 6)));
            endcase
         end
         if ($urandom_range(0, 4) != 0) send_op(FUNC_CLEAR, LABEL_W'($urandom));
         n_pool = $urandom_range(1, 12);
         for (int p = 0; p < n_pool; p++) begin
            case ($urandom_range(0, 7))
               0: pool[p] = 0;
               1: pool[p] = 1;
               2: pool[p] = 32'(TOP_LABEL);
               default: pool[p] = $urandom_range(1, MAX_G - 1);
            endcase
         end
         n_count = $urandom_range(0, 60);
         for (int c = 0; c < n_count; c++) begin
            if ($urandom_range(0, 9) == 0)
               send_op($urandom_range(0, 1) ? FUNC_COUNT : FUNC_UNUSED, LABEL_W'($urandom));
            else
               send_op(FUNC_COUNT, LABEL_W'(pool[$urandom_range(0, n_pool - 1)]));
         end
         n_relabel = $urandom_range(4, 30);
         recounted = 1'b0;
         for (int r = 0; r < n_relabel; r++) begin
            case ($urandom_range(0, 19))
               0: send_op(FUNC_UNUSED, LABEL_W'($urandom));
               1: begin
                  if (!recounted) begin
                     send_op(FUNC_COUNT, LABEL_W'(pool[$urandom_range(0, n_pool - 1)]));
                     recounted = 1'b1;
                  end else begin
                     send_op(FUNC_RELABEL, LABEL_W'($urandom));
                  end
               end
               2, 3: send_op(FUNC_RELABEL, LABEL_W'($urandom));
               default: send_op(FUNC_RELABEL, LABEL_W'(pool[$urandom_range(0, n_pool - 1)]));
            endcase
         end
      end

      // keep only the one large group
      idle_on = 1'b0;
      drain_and_wait();
      write_min(16'd40);
      send_op(FUNC_CLEAR, '0);
      repeat (45) send_op(FUNC_COUNT, TOP_LABEL);
      repeat (3) send_op(FUNC_COUNT, 1);
      send_op(FUNC_RELABEL, TOP_LABEL);
      send_op(FUNC_RELABEL, 1);
      send_op(FUNC_RELABEL, 0);
      send_op(FUNC_COUNT, TOP_LABEL);
      send_op(FUNC_RELABEL, TOP_LABEL);

      drain_and_wait();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
